### design/scaled_font_character_generator_core_macros.svh
// Assertion helpers for the checker file.
`ifndef SCALED_FONT_CHARACTER_GENERATOR_CORE_MACROS_SVH
`define SCALED_FONT_CHARACTER_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, reset low disables.
`define SFCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sfcg check failed");

// Next-cycle implication, reset low disables.
`define SFCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sfcg check failed");

`endif

### design/sfcg_pkg.sv
package sfcg_pkg;

  localparam int CHAR_W      = 5;
  localparam int CHAR_H      = 7;
  localparam int GLYPH_COUNT = 42;
  localparam int MASK_W      = 20;
  localparam int SCALE_W     = 4;   // holds a clamped scale up to SCALE_LIMIT
  localparam int SCALE_LIMIT = 8;
  localparam int GLYPH_W     = 6;

  localparam int DISPLAY_WIDTH_DEF  = 96;
  localparam int DISPLAY_HEIGHT_DEF = 16;
  localparam int MAX_SCALE_DEF      = 4;

  localparam logic [2:0]  SCALE_RST      = 3'd2;
  localparam logic [6:0]  CLIP_START_RST = 7'd0;
  localparam logic [6:0]  CLIP_END_RST   = 7'd96;
  localparam logic [15:0] BORDER_RST     = 16'h0000;
  localparam logic [15:0] COLOR_RST      = 16'hF800;

  // character codes
  localparam logic [7:0] CODE_UPPER_A = 8'h41;
  localparam logic [7:0] CODE_UPPER_Z = 8'h5A;
  localparam logic [7:0] CODE_LOWER_A = 8'h61;
  localparam logic [7:0] CODE_LOWER_Z = 8'h7A;
  localparam logic [7:0] CODE_DIGIT_0 = 8'h30;
  localparam logic [7:0] CODE_DIGIT_9 = 8'h39;
  localparam logic [7:0] CODE_SPACE   = 8'h20;
  localparam logic [7:0] CODE_DASH    = 8'h2D;
  localparam logic [7:0] CODE_DOT     = 8'h2E;
  localparam logic [7:0] CODE_COLON   = 8'h3A;
  localparam logic [7:0] CODE_SLASH   = 8'h2F;
  localparam logic [7:0] CODE_NBSP    = 8'hA0;

  // glyph indexes
  localparam logic [GLYPH_W-1:0] GLYPH_DIGIT_0 = 6'd26;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE   = 6'd36;
  localparam logic [GLYPH_W-1:0] GLYPH_DASH    = 6'd37;
  localparam logic [GLYPH_W-1:0] GLYPH_DOT     = 6'd38;
  localparam logic [GLYPH_W-1:0] GLYPH_COLON   = 6'd39;
  localparam logic [GLYPH_W-1:0] GLYPH_SLASH   = 6'd40;
  localparam logic [GLYPH_W-1:0] GLYPH_NBSP    = 6'd41;

  typedef enum logic [2:0] {
    REG_SCALE      = 3'd0,
    REG_CLIP_START = 3'd1,
    REG_CLIP_END   = 3'd2,
    REG_BORDER     = 3'd3,
    REG_COLOR      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  scale;
    logic [6:0]  clip_start;
    logic [6:0]  clip_end;
    logic [15:0] border_rows;
    logic [15:0] text_color;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [GLYPH_W-1:0] idx;
  } glyph_t;

  // one fetched glyph row on its way to the renderer
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] font;
    logic [15:0]       cx;
    logic              last;
  } row_t;

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    g.hit = 1'b1;
    g.idx = '0;
    if (code inside {[CODE_UPPER_A:CODE_UPPER_Z]}) begin
      g.idx = GLYPH_W'(code - CODE_UPPER_A);
    end else if (code inside {[CODE_LOWER_A:CODE_LOWER_Z]}) begin
      g.idx = GLYPH_W'(code - CODE_LOWER_A);
    end else if (code inside {[CODE_DIGIT_0:CODE_DIGIT_9]}) begin
      g.idx = GLYPH_DIGIT_0 + GLYPH_W'(code - CODE_DIGIT_0);
    end else begin
      case (code)
        CODE_SPACE: g.idx = GLYPH_SPACE;
        CODE_DASH:  g.idx = GLYPH_DASH;
        CODE_DOT:   g.idx = GLYPH_DOT;
        CODE_COLON: g.idx = GLYPH_COLON;
        CODE_SLASH: g.idx = GLYPH_SLASH;
        CODE_NBSP:  g.idx = GLYPH_NBSP;
        default:    g.hit = 1'b0;
      endcase
    end
    return g;
  endfunction

  // top row in the high bits
  function automatic logic [CHAR_W*CHAR_H-1:0] font_glyph(input logic [GLYPH_W-1:0] idx);
    logic [CHAR_W*CHAR_H-1:0] g;
    case (idx)
      6'd0:  g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
      6'd1:  g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
      6'd2:  g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
      6'd3:  g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
      6'd4:  g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
      6'd5:  g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
      6'd6:  g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E};
      6'd7:  g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
      6'd8:  g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
      6'd9:  g = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C};
      6'd10: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
      6'd11: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
      6'd12: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
      6'd13: g = {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11};
      6'd14: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
      6'd15: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
      6'd16: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
      6'd17: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
      6'd18: g = {5'h0E,5'h11,5'h10,5'h0E,5'h01,5'h11,5'h0E};
      6'd19: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
      6'd20: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
      6'd21: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
      6'd22: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
      6'd23: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
      6'd24: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
      6'd25: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
      6'd26: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
      6'd27: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
      6'd28: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
      6'd29: g = {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E};
      6'd30: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
      6'd31: g = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
      6'd32: g = {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E};
      6'd33: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
      6'd34: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
      6'd35: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E};
      6'd37: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
      6'd38: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h04};
      6'd39: g = {5'h00,5'h04,5'h00,5'h00,5'h00,5'h04,5'h00};
      6'd40: g = {5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10};
      default: g = '0;  // space, no-break space and unused codes are blank
    endcase
    return g;
  endfunction

  function automatic logic [CHAR_W-1:0] font_row(input logic [GLYPH_W-1:0] idx,
                                                 input logic [2:0] row);
    logic [CHAR_W*CHAR_H-1:0] g;
    logic [CHAR_W-1:0]        r;
    g = font_glyph(idx);
    r = '0;
    for (int i = 0; i < CHAR_H; i++) begin
      if (row == 3'(i)) r = g[CHAR_W*(CHAR_H-1-i) +: CHAR_W];
    end
    return r;
  endfunction

  // Stretch a 5-dot row horizontally by s; dot 0 is the leftmost (MSB).
  // The dot row shifts left once every s columns, so it runs out after 5 x s bits.
  function automatic logic [MASK_W-1:0] expand_row(input logic [CHAR_W-1:0]  dots,
                                                   input logic [SCALE_W-1:0] s);
    logic [MASK_W-1:0] m;
    logic [CHAR_W-1:0] d;
    int                n;
    m = '0;
    d = '0;
    n = 0;
    for (int k = 1; k <= SCALE_LIMIT; k++) begin
      if (s == SCALE_W'(k)) begin
        d = dots;
        n = 0;
        for (int j = 0; j < MASK_W; j++) begin
          m[j] = d[CHAR_W-1];
          n++;
          if (n == k) begin
            n = 0;
            d = d << 1;
          end
        end
      end
    end
    return m;
  endfunction

endpackage

### design/sfcg_if.sv
interface sfcg_char_if;
  logic              valid;
  logic              ready;
  logic [7:0]        char_code;
  logic              text_start;
  logic signed [15:0] start_x;
  logic signed [7:0]  line_y;

  modport source (output valid, char_code, text_start, start_x, line_y, input ready);
  modport sink   (input valid, char_code, text_start, start_x, line_y, output ready);
endinterface

interface sfcg_row_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  row_y;
  logic signed [15:0] row_x;
  logic [19:0]        pixel_mask;
  logic               row_visible;
  logic [15:0]        color;
  logic               last_row;

  modport source (output valid, row_y, row_x, pixel_mask, row_visible, color, last_row,
                  input ready);
  modport sink   (input valid, row_y, row_x, pixel_mask, row_visible, color, last_row,
                  output ready);
endinterface

### design/sfcg_row_render.sv
module sfcg_row_render #(
  parameter int DISPLAY_WIDTH  = sfcg_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = sfcg_pkg::DISPLAY_HEIGHT_DEF,
  parameter int PY_W           = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfcg_pkg::row_t                  row_i,
  input  logic signed [PY_W-1:0]          row_py_i,
  input  sfcg_pkg::cfg_t                  cfg_i,
  input  logic [sfcg_pkg::SCALE_W-1:0]    scale_i,
  output logic                            adv_o,
  sfcg_row_if.source                      row_o
);

  localparam int XW = 18;  // cursor plus column offset, plus display compare

  logic                           valid_q;
  logic signed [7:0]              y_q;
  logic signed [15:0]             x_q;
  logic [sfcg_pkg::MASK_W-1:0]    mask_q;
  logic                           vis_q;
  logic                           last_q;

  logic [sfcg_pkg::MASK_W-1:0]    dots;
  logic [sfcg_pkg::MASK_W-1:0]    mask_d;
  logic signed [XW-1:0]           lo, hi, px;
  logic                           vis_d;

  assign adv_o = !valid_q || row_o.ready;

  always_comb begin
    dots = sfcg_pkg::expand_row(row_i.font, scale_i);
    lo   = $signed({{(XW-7){1'b0}}, cfg_i.clip_start});
    // clip end and display edge merged into one upper bound
    if ({{(XW-7){1'b0}}, cfg_i.clip_end} < XW'(DISPLAY_WIDTH)) begin
      hi = $signed({{(XW-7){1'b0}}, cfg_i.clip_end});
    end else begin
      hi = $signed(XW'(DISPLAY_WIDTH));
    end
    px     = '0;
    mask_d = '0;
    for (int j = 0; j < sfcg_pkg::MASK_W; j++) begin
      px = $signed({{(XW-16){row_i.cx[15]}}, row_i.cx}) + $signed(XW'(j));
      mask_d[j] = dots[j] && (px >= lo) && (px < hi);
    end
  end

  always_comb begin
    vis_d = !row_py_i[PY_W-1] && (row_py_i < $signed(PY_W'(DISPLAY_HEIGHT)));
    if (row_py_i < $signed(PY_W'(16)) && cfg_i.border_rows[row_py_i[3:0]]) vis_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= row_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && row_i.valid) begin
      y_q    <= row_py_i[7:0];
      x_q    <= row_i.cx;
      mask_q <= mask_d;
      vis_q  <= vis_d;
      last_q <= row_i.last;
    end
  end

  assign row_o.valid       = valid_q;
  assign row_o.row_y       = y_q;
  assign row_o.row_x       = x_q;
  assign row_o.pixel_mask  = mask_q;
  assign row_o.row_visible = vis_q;
  assign row_o.color       = cfg_i.text_color;
  assign row_o.last_row    = last_q;

endmodule

### design/scaled_font_character_generator_core.sv
// After a character's transfer its rows pass the row issue stage, the registered font read and
// the output register. Each mapped character yields one row per cycle unless the output stalls,
// 7 x scale rows in all, set by the row issue counter that reads the font table once per row.
// An unmapped character yields nothing; the next character is taken in the cycle the last row of
// the previous one is issued. Reset (async, active low) empties the pipeline, clears the cursor
// and loads the register defaults.
module scaled_font_character_generator_core #(
  parameter int DISPLAY_WIDTH  = sfcg_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = sfcg_pkg::DISPLAY_HEIGHT_DEF,
  parameter int MAX_SCALE      = sfcg_pkg::MAX_SCALE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfcg_char_if.sink   char_i,
  sfcg_row_if.source  row_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW     = sfcg_pkg::SCALE_W;
  localparam int ROWS_W = $clog2(sfcg_pkg::CHAR_H * MAX_SCALE);
  localparam int SUB_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int PY_W   = ((ROWS_W > 8) ? ROWS_W : 8) + 2;

  sfcg_pkg::cfg_t     cfg_q;
  logic [15:0]        cursor_q, cursor_d;

  // row issue stage
  logic                          busy_q, busy_d;
  logic [sfcg_pkg::GLYPH_W-1:0]  glyph_q, glyph_d;
  logic [15:0]                   cx_q, cx_d;
  logic [7:0]                    ly_q, ly_d;
  logic [ROWS_W-1:0]             r_q, r_d;
  logic [SUB_W-1:0]              sub_q, sub_d;
  logic [2:0]                    gr_q, gr_d;

  // font read stage
  sfcg_pkg::row_t                fetch_q;
  logic signed [PY_W-1:0]        py_q;

  sfcg_pkg::glyph_t              lk;
  logic [SW-1:0]                 s_eff, s_m1;
  logic [7:0]                    rows_m1_w;
  logic [ROWS_W-1:0]             rows_m1;
  logic [15:0]                   base_x;
  logic                          adv, issue, last_issue, accept, cfg_wr;

  // ---------------- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale       <= sfcg_pkg::SCALE_RST;
      cfg_q.clip_start  <= sfcg_pkg::CLIP_START_RST;
      cfg_q.clip_end    <= sfcg_pkg::CLIP_END_RST;
      cfg_q.border_rows <= sfcg_pkg::BORDER_RST;
      cfg_q.text_color  <= sfcg_pkg::COLOR_RST;
    end else if (cfg_wr) begin
      case (sfcg_pkg::reg_idx_e'(paddr[4:2]))
        sfcg_pkg::REG_SCALE:      cfg_q.scale       <= pwdata[2:0];
        sfcg_pkg::REG_CLIP_START: cfg_q.clip_start  <= pwdata[6:0];
        sfcg_pkg::REG_CLIP_END:   cfg_q.clip_end    <= pwdata[6:0];
        sfcg_pkg::REG_BORDER:     cfg_q.border_rows <= pwdata[15:0];
        sfcg_pkg::REG_COLOR:      cfg_q.text_color  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sfcg_pkg::reg_idx_e'(paddr[4:2]))
      sfcg_pkg::REG_SCALE:      prdata = 32'(cfg_q.scale);
      sfcg_pkg::REG_CLIP_START: prdata = 32'(cfg_q.clip_start);
      sfcg_pkg::REG_CLIP_END:   prdata = 32'(cfg_q.clip_end);
      sfcg_pkg::REG_BORDER:     prdata = 32'(cfg_q.border_rows);
      sfcg_pkg::REG_COLOR:      prdata = 32'(cfg_q.text_color);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- scale
  always_comb begin
    s_eff = {1'b0, cfg_q.scale};
    if (s_eff == '0) s_eff = SW'(1);
    if (s_eff > SW'(MAX_SCALE)) s_eff = SW'(MAX_SCALE);
    s_m1      = s_eff - SW'(1);
    rows_m1_w = ({4'b0, s_eff} << 3) - {4'b0, s_eff} - 8'd1;
    rows_m1   = rows_m1_w[ROWS_W-1:0];
  end

  // ---------------- row issue
  assign issue      = busy_q && adv;
  assign last_issue = issue && (r_q == rows_m1);
  assign char_i.ready = !busy_q || last_issue;
  assign accept     = char_i.valid && char_i.ready;

  always_comb begin
    lk       = sfcg_pkg::glyph_lookup(char_i.char_code);
    base_x   = char_i.text_start ? char_i.start_x : cursor_q;
    cursor_d = cursor_q;
    busy_d   = busy_q;
    glyph_d  = glyph_q;
    cx_d     = cx_q;
    ly_d     = ly_q;
    r_d      = r_q;
    sub_d    = sub_q;
    gr_d     = gr_q;
    if (issue) begin
      r_d = r_q + ROWS_W'(1);
      if (sub_q == s_m1[SUB_W-1:0]) begin
        sub_d = '0;
        gr_d  = gr_q + 3'd1;
      end else begin
        sub_d = sub_q + SUB_W'(1);
      end
      if (last_issue) busy_d = 1'b0;
    end
    if (accept) begin
      // space leaves the cursor at the base x; everything else, mapped or not, moves it a cell on
      if (char_i.char_code == sfcg_pkg::CODE_SPACE) begin
        cursor_d = base_x;
      end else begin
        cursor_d = base_x + 16'({s_eff, 2'b00}) + 16'({s_eff, 1'b0});
      end
      if (lk.hit) begin
        busy_d  = 1'b1;
        glyph_d = lk.idx;
        cx_d    = base_x;
        ly_d    = char_i.line_y;
        r_d     = '0;
        sub_d   = '0;
        gr_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cursor_q <= '0;
    end else begin
      busy_q   <= busy_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    cx_q    <= cx_d;
    ly_q    <= ly_d;
    r_q     <= r_d;
    sub_q   <= sub_d;
    gr_q    <= gr_d;
  end

  // ---------------- font table read, registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_q <= '0;
      py_q    <= '0;
    end else begin
      if (adv) begin
        fetch_q.valid <= issue;
      end
      if (issue) begin
        fetch_q.font <= sfcg_pkg::font_row(glyph_q, gr_q);
        fetch_q.cx   <= cx_q;
        fetch_q.last <= (r_q == rows_m1);
        py_q         <= $signed({{(PY_W-8){ly_q[7]}}, ly_q})
                      + $signed({{(PY_W-ROWS_W){1'b0}}, r_q});
      end
    end
  end

  sfcg_row_render #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .PY_W           (PY_W)
  ) u_render (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .row_i    (fetch_q),
    .row_py_i (py_q),
    .cfg_i    (cfg_q),
    .scale_i  (s_eff),
    .adv_o    (adv),
    .row_o    (row_o)
  );

endmodule

### design/sfcg_checker.sv
`include "scaled_font_character_generator_core_macros.svh"

module sfcg_checker #(
  parameter int DISPLAY_WIDTH  = sfcg_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = sfcg_pkg::DISPLAY_HEIGHT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [7:0]  row_y_i,
  input logic [15:0] row_x_i,
  input logic [19:0] pixel_mask_i,
  input logic        row_visible_i,
  input logic        last_row_i,
  input logic        pready_i
);

  logic row_x_off_right;

  assign row_x_off_right = !row_x_i[15] && ({2'b00, row_x_i} >= 18'(DISPLAY_WIDTH));

  // a stalled row stays valid and keeps its y, x, mask and last flag
  `SFCG_ASSERT_NEXT(a_row_hold, clk_i, rst_ni, valid_i && !ready_i,
    valid_i && $stable(row_y_i) && $stable(row_x_i) && $stable(pixel_mask_i)
    && $stable(last_row_i))

  `SFCG_ASSERT_NOW(a_pready, clk_i, rst_ni, 1'b1, pready_i)

  // a visible row is always a real display row, so the wrapped y equals the true y
  `SFCG_ASSERT_NOW(a_vis_row, clk_i, rst_ni, valid_i && row_visible_i,
    !row_y_i[7] && ({1'b0, row_y_i} < 9'(DISPLAY_HEIGHT)))

  // nothing lit when the cell starts past the right edge
  `SFCG_ASSERT_NOW(a_mask_clip, clk_i, rst_ni, valid_i && row_x_off_right,
    pixel_mask_i == '0)

endmodule

bind scaled_font_character_generator_core sfcg_checker #(
  .DISPLAY_WIDTH  (DISPLAY_WIDTH),
  .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
) u_sfcg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (row_o.valid),
  .ready_i       (row_o.ready),
  .row_y_i       (row_o.row_y),
  .row_x_i       (row_o.row_x),
  .pixel_mask_i  (row_o.pixel_mask),
  .row_visible_i (row_o.row_visible),
  .last_row_i    (row_o.last_row),
  .pready_i      (pready)
);

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELL_PITCH = 6;
  localparam int DRAIN_PAD  = 6;
  localparam int CYCLE_CAP  = 400000;

  // 5x7 dots, glyph 0 row 0 in the top bits
  localparam logic [sfcg_pkg::GLYPH_COUNT*sfcg_pkg::CHAR_H*sfcg_pkg::CHAR_W-1:0] FONT_DOTS = {
    5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11, 5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E,
    5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E, 5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E,
    5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F, 5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10,
    5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E, 5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,
    5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E, 5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C,
    5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11, 5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F,
    5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11, 5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,
    5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E, 5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10,
    5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E, 5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11,
    5'h0E,5'h11,5'h10,5'h0E,5'h01,5'h11,5'h0E, 5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,
    5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E, 5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04,
    5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11, 5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11,
    5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04, 5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F,
    5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E, 5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E,
    5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F, 5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E,
    5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02, 5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E,
    5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E, 5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08,
    5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E, 5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E,
    5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00, 5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00,
    5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h04, 5'h00,5'h04,5'h00,5'h00,5'h00,5'h04,5'h00,
    5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10, 5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00
  };

  typedef struct packed {
    logic [7:0]  y;
    logic [15:0] x;
    logic [19:0] mask;
    logic        vis;
    logic [15:0] color;
    logic        last;
  } glyph_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sfcg_char_if char_if_inst ();
  sfcg_row_if  row_if_inst ();

  scaled_font_character_generator_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if_inst),
    .row_o   (row_if_inst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the register file and the cursor
  logic [2:0]  shadow_scale;
  logic [6:0]  shadow_clip_lo;
  logic [6:0]  shadow_clip_hi;
  logic [15:0] shadow_border;
  logic [15:0] shadow_color;
  logic [15:0] cursor_x;

  glyph_row_t pending_rows[$];
  int         mismatch_count;
  int         cycle_count;
  int         src_idle_pct;
  int         snk_stall_pct;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("[scaled_font_character_generator_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    row_if_inst.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : row_check
    glyph_row_t exp_row;
    if (rst_ni && row_if_inst.valid && row_if_inst.ready) begin
      if (pending_rows.size() == 0) begin
        note_mismatch("row transfer with no row pending");
      end else begin
        exp_row = pending_rows.pop_front();
        if (row_if_inst.row_y !== exp_row.y)
          note_mismatch($sformatf("row_y %h, want %h", row_if_inst.row_y, exp_row.y));
        if (row_if_inst.row_x !== exp_row.x)
          note_mismatch($sformatf("row_x %h, want %h", row_if_inst.row_x, exp_row.x));
        if (row_if_inst.pixel_mask !== exp_row.mask)
          note_mismatch($sformatf("pixel_mask %h, want %h",
                                  row_if_inst.pixel_mask, exp_row.mask));
        if (row_if_inst.row_visible !== exp_row.vis)
          note_mismatch($sformatf("row_visible %b, want %b",
                                  row_if_inst.row_visible, exp_row.vis));
        if (row_if_inst.color !== exp_row.color)
          note_mismatch($sformatf("color %h, want %h", row_if_inst.color, exp_row.color));
        if (row_if_inst.last_row !== exp_row.last)
          note_mismatch($sformatf("last_row %b, want %b", row_if_inst.last_row, exp_row.last));
      end
    end
  end

  function automatic int glyph_index(input logic [7:0] code);
    if (code >= sfcg_pkg::CODE_UPPER_A && code <= sfcg_pkg::CODE_UPPER_Z)
      return int'(code - sfcg_pkg::CODE_UPPER_A);
    if (code >= sfcg_pkg::CODE_LOWER_A && code <= sfcg_pkg::CODE_LOWER_Z)
      return int'(code - sfcg_pkg::CODE_LOWER_A);
    if (code >= sfcg_pkg::CODE_DIGIT_0 && code <= sfcg_pkg::CODE_DIGIT_9)
      return int'(sfcg_pkg::GLYPH_DIGIT_0) + int'(code - sfcg_pkg::CODE_DIGIT_0);
    case (code)
      sfcg_pkg::CODE_SPACE: return int'(sfcg_pkg::GLYPH_SPACE);
      sfcg_pkg::CODE_DASH:  return int'(sfcg_pkg::GLYPH_DASH);
      sfcg_pkg::CODE_DOT:   return int'(sfcg_pkg::GLYPH_DOT);
      sfcg_pkg::CODE_COLON: return int'(sfcg_pkg::GLYPH_COLON);
      sfcg_pkg::CODE_SLASH: return int'(sfcg_pkg::GLYPH_SLASH);
      sfcg_pkg::CODE_NBSP:  return int'(sfcg_pkg::GLYPH_NBSP);
      default:              return -1;
    endcase
  endfunction

  function automatic logic [sfcg_pkg::CHAR_W-1:0] glyph_dots(input int g, input int r);
    return FONT_DOTS[(sfcg_pkg::GLYPH_COUNT*sfcg_pkg::CHAR_H-1-(g*sfcg_pkg::CHAR_H+r))
                     *sfcg_pkg::CHAR_W +: sfcg_pkg::CHAR_W];
  endfunction

  // expected rows of one accepted character, then the cursor step
  task automatic render_char(input logic [7:0] code, input logic load,
                             input logic [15:0] sx, input logic signed [7:0] ly);
    int          g;
    int          s;
    int          rows;
    int          cx;
    int          py;
    int          px;
    logic [4:0]  dots;
    glyph_row_t  row;
    if (load) cursor_x = sx;
    s = int'(shadow_scale);
    if (s < 1) s = 1;
    if (s > sfcg_pkg::MAX_SCALE_DEF) s = sfcg_pkg::MAX_SCALE_DEF;
    cx = int'($signed(cursor_x));
    g = glyph_index(code);
    if (g >= 0) begin
      rows = sfcg_pkg::CHAR_H * s;
      for (int r = 0; r < rows; r++) begin
        dots = glyph_dots(g, r / s);
        py = int'(ly) + r;
        row.mask = '0;
        for (int j = 0; j < sfcg_pkg::CHAR_W * s && j < sfcg_pkg::MASK_W; j++) begin
          px = cx + j;
          if (dots[sfcg_pkg::CHAR_W-1-j/s]
              && px >= int'(shadow_clip_lo) && px < int'(shadow_clip_hi)
              && px >= 0 && px < sfcg_pkg::DISPLAY_WIDTH_DEF)
            row.mask[j] = 1'b1;
        end
        row.y     = py[7:0];
        row.x     = cursor_x;
        row.vis   = (py >= 0 && py < sfcg_pkg::DISPLAY_HEIGHT_DEF);
        if (row.vis && py < 16 && shadow_border[py]) row.vis = 1'b0;
        row.color = shadow_color;
        row.last  = (r == rows - 1);
        pending_rows.push_back(row);
      end
    end
    if (code != sfcg_pkg::CODE_SPACE) cursor_x = cursor_x + 16'(CELL_PITCH * s);
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_char(input logic [7:0] code, input logic load,
                           input logic [15:0] sx, input logic [7:0] ly);
    while ($urandom_range(99) < src_idle_pct) begin
      char_if_inst.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if_inst.valid      <= 1'b1;
    char_if_inst.char_code  <= code;
    char_if_inst.text_start <= load;
    char_if_inst.start_x    <= sx;
    char_if_inst.line_y     <= ly;
    @(posedge clk_i);
    while (!char_if_inst.ready) @(posedge clk_i);
    render_char(code, load, sx, ly);
  endtask

  task automatic drain_rows();
    char_if_inst.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    // an unmapped character may still be in flight
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input sfcg_pkg::reg_idx_e idx, input logic [31:0] value);
    drain_rows();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sfcg_pkg::REG_SCALE:      shadow_scale   = value[2:0];
      sfcg_pkg::REG_CLIP_START: shadow_clip_lo = value[6:0];
      sfcg_pkg::REG_CLIP_END:   shadow_clip_hi = value[6:0];
      sfcg_pkg::REG_BORDER:     shadow_border  = value[15:0];
      sfcg_pkg::REG_COLOR:      shadow_color   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic randomize_regs();
    if ($urandom_range(9) < 2) write_reg(sfcg_pkg::REG_SCALE, $urandom_range(7));
    else write_reg(sfcg_pkg::REG_SCALE, $urandom_range(1, sfcg_pkg::MAX_SCALE_DEF));
    if ($urandom_range(9) < 7) begin
      write_reg(sfcg_pkg::REG_CLIP_START, $urandom_range(0, 30));
      write_reg(sfcg_pkg::REG_CLIP_END, $urandom_range(60, 127));
    end else begin
      write_reg(sfcg_pkg::REG_CLIP_START, $urandom_range(127));
      write_reg(sfcg_pkg::REG_CLIP_END, $urandom_range(127));
    end
    write_reg(sfcg_pkg::REG_BORDER, $urandom);
    write_reg(sfcg_pkg::REG_COLOR, $urandom);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0, 1, 2: return sfcg_pkg::CODE_UPPER_A + 8'($urandom_range(25));
      3, 4:    return sfcg_pkg::CODE_LOWER_A + 8'($urandom_range(25));
      5, 6:    return sfcg_pkg::CODE_DIGIT_0 + 8'($urandom_range(9));
      7: begin
        case ($urandom_range(5))
          0:       return sfcg_pkg::CODE_SPACE;
          1:       return sfcg_pkg::CODE_DASH;
          2:       return sfcg_pkg::CODE_DOT;
          3:       return sfcg_pkg::CODE_COLON;
          4:       return sfcg_pkg::CODE_SLASH;
          default: return sfcg_pkg::CODE_NBSP;
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // short strings placed near the display, with some noise
  task automatic random_text(input int n_items);
    int          sent;
    int          len;
    logic [15:0] sx;
    logic [7:0]  ly;
    logic        load;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) sx = 16'($urandom);
      else sx = 16'($urandom_range(0, 130) - 30);
      if ($urandom_range(9) == 0) ly = 8'($urandom);
      else ly = 8'($urandom_range(0, 40) - 24);
      for (int i = 0; i < len && sent < n_items; i++) begin
        load = (i == 0) || ($urandom_range(19) == 0);
        send_char(pick_code(), load, load ? sx : 16'($urandom), ly);
        sent++;
      end
    end
  endtask

  task automatic test_glyph_set();
    send_char(sfcg_pkg::CODE_UPPER_A, 1'b1, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_UPPER_Z, 1'b0, 16'($urandom), 8'd0);
    send_char(sfcg_pkg::CODE_LOWER_A, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_LOWER_Z, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_DIGIT_0, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_DIGIT_9, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_SPACE, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_DASH, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_DOT, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_COLON, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_SLASH, 1'b0, 16'd0, 8'd0);
    send_char(sfcg_pkg::CODE_NBSP, 1'b0, 16'd0, 8'd0);
    // unmapped codes just bump the cursor; boundaries of the letter ranges
    send_char(8'h00, 1'b0, 16'd0, 8'd0);
    send_char(8'hFF, 1'b0, 16'hFFFF, 8'hFF);
    send_char(8'h40, 1'b0, 16'd0, 8'd0);
    send_char(8'h7B, 1'b0, 16'd0, 8'd0);
    send_char(8'h4D, 1'b1, 16'h8000, 8'h80);
    send_char(8'h57, 1'b1, 16'h7FFF, 8'h7F);   // cursor wraps past 0x7FFF
    send_char(8'h48, 1'b0, 16'd0, 8'h7F);
    send_char(8'h42, 1'b1, -16'sd3, -8'sd5);
    send_char(8'h45, 1'b1, 16'd90, 8'd12);
    drain_rows();
  endtask

  task automatic test_register_extremes();
    write_reg(sfcg_pkg::REG_SCALE, 32'd0);
    send_char(8'h58, 1'b1, 16'd4, 8'd2);
    write_reg(sfcg_pkg::REG_SCALE, 32'd7);
    send_char(8'h38, 1'b1, 16'd80, -8'sd10);
    write_reg(sfcg_pkg::REG_SCALE, 32'd1);
    send_char(sfcg_pkg::CODE_DIGIT_0, 1'b1, 16'd0, 8'd9);
    write_reg(sfcg_pkg::REG_SCALE, 32'd4);
    write_reg(sfcg_pkg::REG_CLIP_START, 32'd20);
    write_reg(sfcg_pkg::REG_CLIP_END, 32'd10);
    send_char(8'h57, 1'b1, 16'd12, 8'd0);
    write_reg(sfcg_pkg::REG_CLIP_START, 32'd0);
    write_reg(sfcg_pkg::REG_CLIP_END, 32'h7F);
    write_reg(sfcg_pkg::REG_BORDER, 32'hFFFF);
    write_reg(sfcg_pkg::REG_COLOR, 32'hFFFF);
    send_char(8'h4D, 1'b1, 16'd80, -8'sd4);
    write_reg(sfcg_pkg::REG_CLIP_START, 32'd95);
    write_reg(sfcg_pkg::REG_CLIP_END, 32'd96);
    write_reg(sfcg_pkg::REG_BORDER, 32'hAAAA);
    write_reg(sfcg_pkg::REG_COLOR, 32'h0000);
    send_char(sfcg_pkg::CODE_DASH, 1'b1, 16'd90, 8'd0);
    drain_rows();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    drain_rows();
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    randomize_regs();
    random_text(n_items / 2);
    randomize_regs();
    random_text(n_items - n_items / 2);
    drain_rows();
  endtask

  initial begin
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    char_if_inst.valid      = 1'b0;
    char_if_inst.char_code  = '0;
    char_if_inst.text_start = 1'b0;
    char_if_inst.start_x    = '0;
    char_if_inst.line_y     = '0;
    row_if_inst.ready       = 1'b0;
    mismatch_count          = 0;
    cycle_count             = 0;
    src_idle_pct            = 0;
    snk_stall_pct           = 0;
    shadow_scale            = sfcg_pkg::SCALE_RST;
    shadow_clip_lo          = sfcg_pkg::CLIP_START_RST;
    shadow_clip_hi          = sfcg_pkg::CLIP_END_RST;
    shadow_border           = sfcg_pkg::BORDER_RST;
    shadow_color            = sfcg_pkg::COLOR_RST;
    cursor_x                = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_glyph_set();
    test_register_extremes();
    test_random_traffic(0, 0, 61);
    test_random_traffic(85, 0, 61);
    test_random_traffic(0, 85, 61);
    test_random_traffic(34, 34, 61);

    if (mismatch_count == 0) begin
      $display("[scaled_font_character_generator_core] OK");
    end else begin
      $display("[scaled_font_character_generator_core] ERROR");
    end
    $finish;
  end

endmodule
